[hdl/rfetd_pkg.sv]
// ----------------------------------------------------------------------------
// rfetd_pkg
// Shared types and constants of the RF entity table with activity decay.
// ----------------------------------------------------------------------------
package rfetd_pkg;

  localparam int ENTITY_SLOTS_DEF = 16;

  localparam int HASH_W  = 32;
  localparam int PROTO_W = 4;
  localparam int Q_W     = 32;
  localparam int REG_W   = 16;
  localparam int OP_W    = 2;
  localparam int SLOT_W  = 4;
  localparam int CIDX_W  = 8;

  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 72;

  localparam logic [OP_W-1:0] OP_INGEST = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [CIDX_W-1:0] REG_DECAY_RATE    = 8'd0;
  localparam logic [CIDX_W-1:0] REG_ACTIVITY_FLOOR = 8'd1;
  localparam logic [CIDX_W-1:0] REG_PING_LEVEL    = 8'd2;
  localparam logic [CIDX_W-1:0] REG_INITIAL_LEVEL = 8'd3;

  localparam logic [REG_W-1:0] DECAY_RATE_RST     = 16'd5242;
  localparam logic [REG_W-1:0] ACTIVITY_FLOOR_RST = 16'd655;
  localparam logic [REG_W-1:0] PING_LEVEL_RST     = 16'd13107;
  localparam logic [REG_W-1:0] INITIAL_LEVEL_RST  = 16'd7864;

  localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [PROTO_W-1:0] protocol;
    logic [Q_W-1:0]     strength;
    logic [Q_W-1:0]     distance;
  } entry_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic ok;
  } lookup_t;

endpackage

[hdl/rfetd_div.sv]
// ----------------------------------------------------------------------------
// rfetd_div
// Restoring divider for the distance estimate 2^32 / den, one quotient bit
// per cycle, with truncation toward zero and signed 32-bit saturation.
// ----------------------------------------------------------------------------
module rfetd_div
  import rfetd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [Q_W:0]  den,
  output logic                 done,
  output logic [Q_W-1:0]       quot
);

  localparam int DIV_BITS = Q_W + 1;
  localparam int CNT_W    = $clog2(DIV_BITS);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(DIV_BITS - 1);

  logic             busy;
  logic             fin;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [Q_W-1:0]   mag;
  logic [Q_W-1:0]   rem;
  logic [Q_W:0]     q;
  logic [Q_W:0]     trial;
  logic             ge;
  logic [Q_W-1:0]   sat;

  // dividend is 2^32: its only set bit enters on the first step
  assign trial = {rem, (cnt == CNT_TOP)};
  assign ge    = trial >= {1'b0, mag};

  always_comb begin
    if (!neg) begin
      sat = (q[Q_W] || q[Q_W-1]) ? Q_MAX : q[Q_W-1:0];
    end else begin
      sat = (q[Q_W] || (q[Q_W-1] && (|q[Q_W-2:0]))) ? Q_MIN : (Q_W)'(-q[Q_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        done <= (den == '0);
        busy <= (den != '0);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= CNT_TOP;
      rem  <= '0;
      neg  <= den[Q_W];
      mag  <= den[Q_W] ? (Q_W)'(-den) : den[Q_W-1:0];
      quot <= Q_MAX;
    end else if (busy) begin
      rem <= ge ? (Q_W)'(trial - {1'b0, mag}) : trial[Q_W-1:0];
      q   <= {q[Q_W-1:0], ge};
      cnt <= cnt - 1'b1;
    end else if (fin) begin
      quot <= sat;
    end
  end

endmodule

[hdl/rfetd_table.sv]
// ----------------------------------------------------------------------------
// rfetd_table
// Entity memory with a fill count; scans the filled slots for a hash match
// one read a cycle and writes the record of a committed ingest.
// ----------------------------------------------------------------------------
module rfetd_table
  import rfetd_pkg::*;
#(
  parameter  int SLOTS = ENTITY_SLOTS_DEF,
  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [HASH_W-1:0] key,
  output lookup_t           res,
  output logic [IW-1:0]     slot,
  input  logic              commit,
  input  entry_t            wr_rec
);

  localparam int CW = $clog2(SLOTS + 1);

  entry_t mem [SLOTS];
  entry_t rd_q;

  logic              busy;
  logic [CW-1:0]     fill;
  logic [CW-1:0]     ptr;
  logic              chk_vld;
  logic [IW-1:0]     chk_idx;
  logic [HASH_W-1:0] key_q;
  logic              match;
  logic              at_end;
  logic              finish;
  logic              issue;

  assign match  = chk_vld && (rd_q.hash == key_q);
  assign at_end = (ptr == fill);
  assign finish = busy && (match || at_end);
  assign issue  = busy && !at_end && !match;

  always_ff @(posedge clk) begin
    if (commit) begin
      mem[slot] <= wr_rec;
    end
    rd_q <= mem[ptr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      chk_vld <= 1'b0;
      fill    <= '0;
      res     <= '0;
    end else begin
      if (start) begin
        busy     <= 1'b1;
        chk_vld  <= 1'b0;
        res.done <= 1'b0;
      end else begin
        chk_vld <= issue;
        if (finish) begin
          busy     <= 1'b0;
          res.done <= 1'b1;
          res.hit  <= match;
          res.ok   <= match || (fill != CW'(SLOTS));
        end
      end
      if (commit && !res.hit) begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ptr   <= '0;
      key_q <= key;
    end else begin
      if (issue) begin
        ptr     <= ptr + 1'b1;
        chk_idx <= ptr[IW-1:0];
      end
      if (finish) begin
        slot <= match ? chk_idx : fill[IW-1:0];
      end
    end
  end

endmodule

[hdl/rf_entity_table_with_decay_top.sv]
// ----------------------------------------------------------------------------
// rf_entity_table_with_decay_top
// Table of RF entities keyed by hash, with a Q16.16 activity level that is
// set by ingests and updated by decay ticks.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A query goes straight to the output
// state, and a tick passes through the multiply and decay states first. An
// ingest runs the slot scan (one memory read a cycle over the filled slots)
// alongside a 33-step restoring divider for the distance, and goes to the
// output state once both are done. No memory clearing is needed after
// reset: a fill count marks the valid slots.
// ----------------------------------------------------------------------------
module rf_entity_table_with_decay_top
  import rfetd_pkg::*;
#(
  parameter int ENTITY_SLOTS = ENTITY_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // dev_hash[31:0], protocol[35:32], rssi[67:36], elapsed[99:68], zero pad
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // opcode[1:0]
  input  logic [OP_W-1:0]       s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // slot[3:0], distance[35:4], activity[67:36], zero pad
  output logic [M_TDATA_W-1:0]  m_tdata,
  // accepted[0]
  output logic [0:0]            m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CIDX_W-1:0]     cfg_index,
  input  logic [REG_W-1:0]      cfg_data
);

  localparam int IW = (ENTITY_SLOTS > 1) ? $clog2(ENTITY_SLOTS) : 1;
  localparam int PROD_W = REG_W + 1 + Q_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_INGEST = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_DECAY  = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0]               state;
  logic [REG_W-1:0]         decay_rate;
  logic [REG_W-1:0]         activity_floor;
  logic [REG_W-1:0]         ping_level;
  logic signed [Q_W-1:0]    activity;

  logic [HASH_W-1:0]        hash_q;
  logic [PROTO_W-1:0]       proto_q;
  logic [Q_W-1:0]           rssi_q;
  logic signed [Q_W-1:0]    elapsed_q;
  logic signed [PROD_W-1:0] prod;

  logic                     res_acc;
  logic [SLOT_W-1:0]        res_slot;
  logic [Q_W-1:0]           res_dist;

  logic                     in_acc;
  logic                     ingest_start;
  logic signed [Q_W:0]      den;
  logic                     div_done;
  logic [Q_W-1:0]           div_quot;
  lookup_t                  look;
  logic [IW-1:0]            look_slot;
  logic                     commit;
  entry_t                   wr_rec;

  logic signed [Q_W:0]      decay;
  logic signed [Q_W+1:0]    act_diff;
  logic signed [Q_W-1:0]    act_decayed;

  assign s_tready     = (state == ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign in_acc       = s_tvalid && s_tready;
  assign ingest_start = in_acc && (s_tuser == OP_INGEST);
  assign den          = (Q_W+1)'($signed(s_tdata[67:36])) + (Q_W+1)'(33'sd65536);
  assign commit       = (state == ST_INGEST) && look.done && div_done && look.ok;

  assign wr_rec = '{hash: hash_q, protocol: proto_q, strength: rssi_q, distance: div_quot};

  rfetd_table #(
    .SLOTS (ENTITY_SLOTS)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .start  (ingest_start),
    .key    (s_tdata[31:0]),
    .res    (look),
    .slot   (look_slot),
    .commit (commit),
    .wr_rec (wr_rec)
  );

  rfetd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ingest_start),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign decay    = prod[PROD_W-1:16];
  assign act_diff = (Q_W+2)'(activity) - (Q_W+2)'(decay);

  always_comb begin
    if ((Q_W+1)'(activity) > decay) begin
      act_decayed = (act_diff > (Q_W+2)'($signed({1'b0, Q_MAX}))) ? Q_MAX
                                                                 : act_diff[Q_W-1:0];
    end else begin
      act_decayed = (Q_W)'(activity_floor);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_rate     <= DECAY_RATE_RST;
      activity_floor <= ACTIVITY_FLOOR_RST;
      ping_level     <= PING_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DECAY_RATE:     decay_rate     <= cfg_data;
        REG_ACTIVITY_FLOOR: activity_floor <= cfg_data;
        REG_PING_LEVEL:     ping_level     <= cfg_data;
        // initial level is fixed at its reset value; writes here are ignored
        REG_INITIAL_LEVEL:  ;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      activity <= (Q_W)'(INITIAL_LEVEL_RST);
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (s_tuser)
              OP_INGEST: state <= ST_INGEST;
              OP_TICK:   state <= ST_MUL;
              default:   state <= ST_OUT;
            endcase
          end
        end
        ST_INGEST: begin
          if (look.done && div_done) begin
            if (look.ok) begin
              activity <= (Q_W)'(ping_level);
            end
            state <= ST_OUT;
          end
        end
        ST_MUL: begin
          state <= ST_DECAY;
        end
        ST_DECAY: begin
          activity <= act_decayed;
          state    <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hash_q    <= s_tdata[31:0];
      proto_q   <= s_tdata[35:32];
      rssi_q    <= s_tdata[67:36];
      elapsed_q <= s_tdata[99:68];
      res_acc   <= 1'b0;
      res_slot  <= '0;
      res_dist  <= '0;
    end
    if (state == ST_MUL) begin
      prod <= $signed({1'b0, decay_rate}) * elapsed_q;
    end
    if (commit) begin
      res_acc  <= 1'b1;
      res_slot <= SLOT_W'(look_slot);
      res_dist <= div_quot;
    end
    if ((state == ST_OUT) && (!m_tvalid || m_tready)) begin
      m_tdata <= {4'b0, activity, res_dist, res_slot};
      m_tuser <= res_acc;
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_tready)
    else $error("item taken while another is in flight");

  a_ping_after_ingest: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[67:36] == (Q_W)'(ping_level))
    else $error("accepted ingest does not report ping level");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[35:0] == '0)
    else $error("slot or distance set on a result without ingest");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RF entity table with activity decay. A local
// predictor tracks the slot table, the activity level and the registers, and
// each result from the block is compared field by field with the oldest
// pending prediction. Directed items cover slot allocation, a full table,
// the distance saturation cases and the decay corners; random phases under
// varied register settings, random idling on both sides and a long output
// hold-off follow.
// ----------------------------------------------------------------------------
module testbench;
  import rfetd_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic           accepted;
    logic [SLOT_W-1:0] slot;
    logic [Q_W-1:0] distance;
    logic [Q_W-1:0] activity;
  } sighting_report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [OP_W-1:0]      s_tuser = OP_QUERY;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [0:0]           m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CIDX_W-1:0]    cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;

  // predictor state
  bit               slot_used [ENTITY_SLOTS_DEF];
  logic [HASH_W-1:0] slot_hash [ENTITY_SLOTS_DEF];
  longint           activity_now = longint'(INITIAL_LEVEL_RST);
  logic [REG_W-1:0] cur_rate  = DECAY_RATE_RST;
  logic [REG_W-1:0] cur_floor = ACTIVITY_FLOOR_RST;
  logic [REG_W-1:0] cur_ping  = PING_LEVEL_RST;
  logic [REG_W-1:0] cur_init  = INITIAL_LEVEL_RST;

  sighting_report_t awaited_reports [$];
  int errors = 0;
  int idle_cycles = 0;
  bit src_quiet = 1'b0;
  bit src_offering = 1'b0;
  bit sink_quiet = 1'b0;
  int sink_hold_req = 0;
  int sink_hold = 0;
  int sink_stall = 0;

  rf_entity_table_with_decay_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [Q_W-1:0] distance_estimate(input logic signed [Q_W-1:0] rssi);
    longint den;
    longint q;
    den = longint'(rssi);
    den = den + 65536;
    if (den == 0) return Q_MAX;
    q = 64'sd4294967296 / den;
    if (q > 64'sd2147483647) return Q_MAX;
    if (q < -64'sd2147483648) return Q_MIN;
    return q[Q_W-1:0];
  endfunction

  task automatic update_table_and_level(input logic [OP_W-1:0] op,
                                        input logic [HASH_W-1:0] hash,
                                        input logic signed [Q_W-1:0] rssi,
                                        input logic signed [Q_W-1:0] elapsed);
    sighting_report_t rep;
    int target;
    longint rate_l;
    longint el;
    longint decay;
    longint nv;
    rep = '0;
    target = -1;
    if (op == OP_INGEST) begin
      for (int i = 0; i < ENTITY_SLOTS_DEF; i++) begin
        if (slot_used[i] && slot_hash[i] == hash) begin
          target = i;
          break;
        end
        if (!slot_used[i] && target < 0) target = i;
      end
      if (target >= 0) begin
        slot_used[target] = 1'b1;
        slot_hash[target] = hash;
        activity_now = longint'(cur_ping);
        rep.accepted = 1'b1;
        rep.slot = target[SLOT_W-1:0];
        rep.distance = distance_estimate(rssi);
      end
    end else if (op == OP_TICK) begin
      rate_l = longint'(cur_rate);
      el = longint'(elapsed);
      decay = (rate_l * el) >>> 16;
      if (activity_now > decay) begin
        nv = activity_now - decay;
        activity_now = (nv > 64'sd2147483647) ? 64'sd2147483647 : nv;
      end else begin
        activity_now = longint'(cur_floor);
      end
    end
    rep.activity = activity_now[Q_W-1:0];
    awaited_reports.push_back(rep);
  endtask

  task automatic send_item(input logic [OP_W-1:0] op, input logic [HASH_W-1:0] hash,
                           input logic [PROTO_W-1:0] proto,
                           input logic signed [Q_W-1:0] rssi,
                           input logic signed [Q_W-1:0] elapsed);
    int gap;
    s_tvalid <= 1'b1;
    src_offering = 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, elapsed, rssi, proto, hash};
    do @(posedge clk); while (!s_tready);
    update_table_and_level(op, hash, rssi, elapsed);
    gap = src_quiet ? 0 : gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      src_offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_reports();
    if (src_offering) begin
      s_tvalid <= 1'b0;
      src_offering = 1'b0;
    end
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DECAY_RATE:     cur_rate = val;
      REG_ACTIVITY_FLOOR: cur_floor = val;
      REG_PING_LEVEL:     cur_ping = val;
      REG_INITIAL_LEVEL:  cur_init = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [REG_W-1:0] pick_reg_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 4) return '1;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic test_directed();
    send_item(OP_QUERY, 32'h0, 4'h0, 32'sh0, 32'sh0);
    send_item(OP_SPARE, 32'hFFFF_FFFF, 4'hF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_item(OP_TICK, 32'h0, 4'h0, 32'sh0, 32'sh0);
    send_item(OP_INGEST, 32'h0, 4'h0, 32'sh0, 32'sh0);
    send_item(OP_INGEST, 32'hFFFF_FFFF, 4'hF, -32'sd65536, 32'sh0);
    send_item(OP_INGEST, 32'h0, 4'h5, -32'sd65535, 32'sh0);
    send_item(OP_INGEST, 32'h0000_0001, 4'hA, -32'sd65537, 32'sh0);
    send_item(OP_INGEST, 32'h8000_0000, 4'h1, 32'sh7FFF_FFFF, 32'sh0);
    send_item(OP_INGEST, 32'h7FFF_FFFF, 4'h2, 32'sh8000_0000, 32'sh0);
    send_item(OP_TICK, 32'h0, 4'h0, 32'sh0, 32'sh7FFF_FFFF);
    send_item(OP_TICK, 32'h0, 4'h0, 32'sh0, -32'sd1);
    // fill the remaining slots
    for (int k = 0; k < 11; k++) begin
      send_item(OP_INGEST, 32'h1000_0000 + k * 32'h0101, k[3:0],
                (k == 0) ? -32'sd131072 : (k == 1) ? -32'sd65534 : $urandom, $urandom);
    end
    send_item(OP_INGEST, 32'h5A5A_5A5A, 4'h3, 32'sh0, 32'sh0);
    send_item(OP_INGEST, 32'hFFFF_FFFF, 4'h4, -32'sd65533, 32'sh0);
    send_item(OP_QUERY, 32'h0, 4'h0, 32'sh0, 32'sh0);
    wait_for_reports();
  endtask

  task automatic test_register_extremes();
    wait_for_reports();
    write_reg(REG_DECAY_RATE, 16'hFFFF);
    write_reg(REG_ACTIVITY_FLOOR, 16'h0000);
    write_reg(REG_PING_LEVEL, 16'hFFFF);
    write_reg(REG_INITIAL_LEVEL, 16'hFFFF);
    write_reg(8'd4, 16'h1234);
    write_reg(8'hFF, 16'hFFFF);
    send_item(OP_INGEST, 32'h0, 4'h0, 32'sh0, 32'sh0);
    send_item(OP_TICK, 32'h0, 4'h0, 32'sh0, 32'sh8000_0000);
    send_item(OP_TICK, 32'h0, 4'h0, 32'sh0, 32'sd1);
    send_item(OP_TICK, 32'h0, 4'h0, 32'sh0, 32'sh7FFF_FFFF);
    send_item(OP_TICK, 32'h0, 4'h0, 32'sh0, 32'sh7FFF_FFFF);
    send_item(OP_TICK, 32'h0, 4'h0, 32'sh0, 32'sh0);
    wait_for_reports();
    write_reg(REG_DECAY_RATE, 16'h0000);
    write_reg(REG_ACTIVITY_FLOOR, 16'hFFFF);
    write_reg(REG_PING_LEVEL, 16'h0000);
    write_reg(REG_INITIAL_LEVEL, 16'h0000);
    send_item(OP_INGEST, 32'h8000_0000, 4'h9, 32'sh0, 32'sh0);
    send_item(OP_TICK, 32'h0, 4'h0, 32'sh0, 32'sh8000_0000);
    send_item(OP_TICK, 32'h0, 4'h0, 32'sh0, 32'sh7FFF_FFFF);
    send_item(OP_QUERY, 32'h0, 4'h0, 32'sh0, 32'sh0);
    wait_for_reports();
  endtask

  task automatic test_random_traffic(input int count);
    logic [OP_W-1:0] op;
    logic [HASH_W-1:0] hash;
    logic signed [Q_W-1:0] rssi;
    logic signed [Q_W-1:0] elapsed;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      op = (r < 45) ? OP_INGEST : (r < 75) ? OP_TICK : (r < 95) ? OP_QUERY : OP_SPARE;
      hash = ($urandom_range(0, 3) == 0) ? $urandom : slot_hash[4'($urandom_range(0, 15))];
      r = $urandom_range(0, 99);
      if (r < 30) rssi = -32'sd65536 + int'($urandom_range(0, 8)) - 4;
      else if (r < 40) rssi = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      else rssi = $urandom;
      r = $urandom_range(0, 99);
      if (r < 60) elapsed = int'($urandom_range(0, 524288)) - 262144;
      else if (r < 70) elapsed = int'($urandom_range(0, 32)) - 16;
      else elapsed = $urandom;
      send_item(op, hash, 4'($urandom_range(0, 15)), rssi, elapsed);
    end
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 4; p++) begin
      wait_for_reports();
      write_reg(REG_DECAY_RATE, pick_reg_value());
      write_reg(REG_ACTIVITY_FLOOR, pick_reg_value());
      write_reg(REG_PING_LEVEL, pick_reg_value());
      write_reg(REG_INITIAL_LEVEL, pick_reg_value());
      if (p == 3) write_reg(8'($urandom_range(4, 255)), pick_reg_value());
      src_quiet = (p == 1);
      sink_quiet = (p == 2);
      test_random_traffic(380);
    end
    wait_for_reports();
    src_quiet = 1'b0;
    sink_quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    wait_for_reports();
    src_quiet = 1'b1;
    sink_hold_req = 400;
    test_random_traffic(40);
    wait_for_reports();
    src_quiet = 1'b0;
    // one item at a time, each fully answered before the next
    for (int k = 0; k < 10; k++) begin
      test_random_traffic(1);
      wait_for_reports();
    end
  endtask

  always @(posedge clk) begin : sink
    sighting_report_t want;
    if (m_tvalid && m_tready) begin
      if (awaited_reports.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        want = awaited_reports.pop_front();
        if (m_tuser[0] !== want.accepted) begin
          $error("accepted mismatch: expected %0d, got %0d", want.accepted, m_tuser[0]);
          errors++;
        end
        if (m_tdata[3:0] !== want.slot) begin
          $error("slot mismatch: expected %0d, got %0d", want.slot, m_tdata[3:0]);
          errors++;
        end
        if (m_tdata[35:4] !== want.distance) begin
          $error("distance mismatch: expected %0d, got %0d",
                 $signed(want.distance), $signed(m_tdata[35:4]));
          errors++;
        end
        if (m_tdata[67:36] !== want.activity) begin
          $error("activity mismatch: expected %0d, got %0d",
                 $signed(want.activity), $signed(m_tdata[67:36]));
          errors++;
        end
      end
    end
    if (sink_hold_req > 0) begin
      sink_hold = sink_hold_req;
      sink_hold_req = 0;
    end
    if (sink_hold > 0) begin
      sink_hold--;
      m_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!sink_quiet && (m_tvalid || $urandom_range(0, 7) == 0)) sink_stall = gap_len();
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_extremes();
    test_random_phases();
    test_backpressure();
    wait_for_reports();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/rfetd_pkg.sv
hdl/rfetd_div.sv
hdl/rfetd_table.sv
hdl/rf_entity_table_with_decay_top.sv
verif/testbench.sv
